// ===== design/wpm_pkg.sv =====
package wpm_pkg;

	// pattern capacity and derived widths
	localparam int MAX_PATTERN = 32;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// wildcard bytes
	localparam logic [7:0] STAR_BYTE = 8'd42;
	localparam logic [7:0] ANY_BYTE = 8'd63;

	// item actions
	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEXT   = 2'd2,
		ACT_END    = 2'd3
	} action_t;

endpackage

// ===== design/wildcard_pattern_matcher.sv =====
// result: an end item's result is registered in the result register as the item leaves the item register
// throughput: one item per cycle; the prefix vector update is one carry-chain add
// over the stored pattern, so text bytes stream with no bubbles; an end item waits
// in the item register only while the previous result is held by result_stall
// reset (arst_n low, asynchronous): pattern empty, overflow clear, prefix vector
// at its start value, item and result registers empty; the pattern bytes are not cleared
module wildcard_pattern_matcher
	import wpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] action,
	input  logic [7:0] symbol,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       matched,
	output logic       overflow
);

	// item register
	logic          item_valid_s1;
	action_t       act_s1;
	logic [7:0]    sym_s1;

	// pattern state
	logic [7:0]          pat_q [MAX_PATTERN];
	logic [LEN_W-1:0]    len_q;
	logic [MAX_PATTERN:0] vec_q;
	logic [MAX_PATTERN:0] start_q;
	logic                ovf_q;

	// result register
	logic result_valid_q;
	logic matched_q;
	logic overflow_q;

	// step control
	logic             go;
	logic             room;
	logic [LEN_W-1:0] len_nx;
	logic             sym_star;

	// prefix vector update
	logic [MAX_PATTERN-1:0] prop;
	logic [MAX_PATTERN-1:0] gen;
	logic [MAX_PATTERN:0]   add_a;
	logic [MAX_PATTERN:0]   add_b;
	logic [MAX_PATTERN:0]   add_sum;
	logic [MAX_PATTERN:0]   carries;
	logic [MAX_PATTERN:0]   vec_text;

	// the item in the register moves on unless it is an end item facing a held result
	assign go = item_valid_s1 && !(act_s1 == ACT_END && result_valid_q && result_stall);
	assign item_stall = item_valid_s1 && !go;

	assign room = (len_q < LEN_W'(MAX_PATTERN));
	assign len_nx = len_q + LEN_W'(1);
	assign sym_star = (sym_s1 == STAR_BYTE);

	// per position: a star propagates the bit of the prefix before it, others kill
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			logic in_rng;
			logic is_star;
			logic hit;
			in_rng = (LEN_W'(j) < len_q);
			is_star = (pat_q[j] == STAR_BYTE);
			hit = (pat_q[j] == ANY_BYTE) || (pat_q[j] == sym_s1);
			prop[j] = in_rng && is_star;
			gen[j] = in_rng && (is_star ? vec_q[j + 1] : (hit && vec_q[j]));
		end
	end

	// the star chain is a carry chain: generate = gen, propagate = star
	assign add_a = {1'b0, gen};
	assign add_b = {1'b0, gen | prop};
	assign add_sum = add_a + add_b;
	assign carries = add_sum ^ add_a ^ add_b;
	assign vec_text = {carries[MAX_PATTERN:1], 1'b0};

	// pattern bytes, written in order, no reset
	always_ff @(posedge clk) begin
		if (go && act_s1 == ACT_APPEND && room) begin
			pat_q[len_q[IDX_W-1:0]] <= sym_s1;
		end
	end

	// item register, pattern state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			len_q <= '0;
			vec_q <= (MAX_PATTERN + 1)'(1);
			start_q <= (MAX_PATTERN + 1)'(1);
			ovf_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// input transfer
			if (!item_stall) begin
				item_valid_s1 <= item_valid;
			end
			// an end item loads the result register, a result transfer frees it
			if (go && act_s1 == ACT_END) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (go) begin
				case (act_s1)
					ACT_CLEAR: begin
						len_q <= '0;
						ovf_q <= 1'b0;
						vec_q <= (MAX_PATTERN + 1)'(1);
						start_q <= (MAX_PATTERN + 1)'(1);
					end
					ACT_APPEND: begin
						if (room) begin
							vec_q[len_nx] <= sym_star && vec_q[len_q];
							start_q[len_nx] <= sym_star && start_q[len_q];
							len_q <= len_nx;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					ACT_TEXT: begin
						vec_q <= vec_text;
					end
					ACT_END: begin
						vec_q <= start_q;
					end
					default: begin
						vec_q <= vec_q;
					end
				endcase
			end
		end
	end

	// item payload, no reset
	always_ff @(posedge clk) begin
		if (!item_stall) begin
			act_s1 <= action_t'(action);
			sym_s1 <= symbol;
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (go && act_s1 == ACT_END) begin
			matched_q <= vec_q[len_q] && !ovf_q;
			overflow_q <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign matched = matched_q;
	assign overflow = overflow_q;

`ifndef SYNTHESIS
	// pattern length stays within capacity
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	// overflow only rises when the pattern is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> len_q == LEN_W'(MAX_PATTERN))
		else $error("overflow set with room left");

	// an end item restores the start vector
	a_end_restore: assert property (@(posedge clk) disable iff (!arst_n)
		go && act_s1 == ACT_END |=> vec_q == $past(start_q))
		else $error("prefix vector not restored after end");

	// a reported match never comes with overflow
	a_match_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(matched && overflow))
		else $error("match reported with overflow");

	// the input side only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid_q && result_stall && act_s1 == ACT_END)
		else $error("input stalled without a held result");
`endif

endmodule
